>>> rtl/ssm_pkg.sv
// Shared types, constants and helper functions of the streaming substring matcher.
package ssm_pkg;

  localparam int MAX_NEEDLE = 16;
  localparam int CHAR_W = 16;
  localparam int WORD_W = 64;
  localparam int CHARS_PER_WORD = WORD_W / CHAR_W;
  localparam int NUM_WORDS = (MAX_NEEDLE + CHARS_PER_WORD - 1) / CHARS_PER_WORD;
  localparam int LEN_W = 5;
  localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int POS_W = 15;
  localparam int CFG_IDX_W = 3;
  localparam logic [POS_W-1:0] COUNT_MAX = '1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_NEEDLE);
  localparam logic [CHAR_W-1:0] LOWER_A = 16'h0061;
  localparam logic [CHAR_W-1:0] LOWER_Z = 16'h007A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 16'h0020;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LENGTH    = 3'd0,
    CFG_CASE_INSENSITIVE = 3'd1,
    CFG_NEEDLE_WORD_0    = 3'd2,
    CFG_NEEDLE_WORD_1    = 3'd3,
    CFG_NEEDLE_WORD_2    = 3'd4,
    CFG_NEEDLE_WORD_3    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic              accept;
    logic              last;
    logic              case_insensitive;
    logic [CHAR_W-1:0] hay_char;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic ci);
    logic [CHAR_W-1:0] r;
    r = c;
    if (ci && c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

endpackage

>>> rtl/streaming_substring_matcher_core.sv
// Top level of the streaming substring matcher: cell chain, counters and result register.
//
// The haystack streams in on the in_ channel, one 16-bit character per
// transaction, with in_last_char set on its final character. The needle,
// its length and the case folding mode are written through the cfg_ port;
// the user must do so only while no haystack is in flight, which the block
// does not enforce; cfg_ready is always high. Each cell of a row of sixteen
// holds one needle character and one bit of the partial-match vector, and
// every accepted character advances the whole row by one position. While
// in_stall is low, a new character can be accepted in every cycle.
// The result for a haystack appears on the out_ channel in the cycle after
// its last character is accepted, from a single output register.
// When the receiver holds out_stall high while a result waits, in_stall
// rises and stays high until that result is taken; otherwise the input
// is never stalled.
// Reset clears the configuration registers, the partial-match vector, the
// character count and the pending result. The per-haystack state also
// clears after every last character.
module streaming_substring_matcher_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [15:0]                        in_haystack_char,
  input  logic                               in_last_char,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [14:0]                        out_match_position,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                        cfg_data
);
  import ssm_pkg::*;

  logic [LEN_W-1:0]      needle_length_r;
  logic                  case_insensitive_r;
  logic [POS_W-1:0]      char_count_r;
  logic                  found_flag_r;
  logic [POS_W-1:0]      first_pos_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [POS_W-1:0]      out_pos_r;

  logic                  cfg_wr;
  logic [NUM_WORDS-1:0]  word_we;
  logic                  accept;
  logic [LEN_W-1:0]      len_eff;
  logic [IDX_W-1:0]      top_idx;
  logic [MAX_NEEDLE-1:0] pm_bits;
  logic [MAX_NEEDLE-1:0] hits;
  logic                  hit;
  logic [POS_W-1:0]      cand_pos;
  logic                  found_nxt;
  logic [POS_W-1:0]      pos_nxt;
  cell_ctl_t             ctl;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_comb begin
    word_we = '0;
    if (cfg_wr) begin
      unique case (cfg_index)
        CFG_NEEDLE_WORD_0: word_we[0] = 1'b1;
        CFG_NEEDLE_WORD_1: if (NUM_WORDS > 1) word_we[NUM_WORDS > 1 ? 1 : 0] = 1'b1;
        CFG_NEEDLE_WORD_2: if (NUM_WORDS > 2) word_we[NUM_WORDS > 2 ? 2 : 0] = 1'b1;
        CFG_NEEDLE_WORD_3: if (NUM_WORDS > 3) word_we[NUM_WORDS > 3 ? 3 : 0] = 1'b1;
        default: word_we = '0;
      endcase
    end
  end

  always_comb begin
    len_eff = (needle_length_r > MAX_LEN) ? MAX_LEN : needle_length_r;
    top_idx = IDX_W'(len_eff - LEN_W'(1));
    ctl.accept           = accept;
    ctl.last             = in_last_char;
    ctl.case_insensitive = case_insensitive_r;
    ctl.hay_char         = fold_char(in_haystack_char, case_insensitive_r);
  end

  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
    localparam int W = j / CHARS_PER_WORD;
    localparam int S = j % CHARS_PER_WORD;
    logic prev;
    logic en;
    if (j == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = pm_bits[j-1];
    end
    assign en = (LEN_W'(j) < len_eff);
    ssm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .enable   (en),
      .cfg_we   (word_we[W]),
      .cfg_char (cfg_data[S*CHAR_W +: CHAR_W]),
      .prev_bit (prev),
      .pm_bit   (pm_bits[j]),
      .hit_nxt  (hits[j])
    );
  end

  always_comb begin
    hit       = (len_eff != '0) & hits[top_idx];
    cand_pos  = char_count_r - POS_W'(len_eff) + POS_W'(1);
    found_nxt = found_flag_r | hit;
    pos_nxt   = found_flag_r ? first_pos_r : (hit ? cand_pos : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_length_r    <= '0;
      case_insensitive_r <= 1'b0;
      char_count_r       <= '0;
      found_flag_r       <= 1'b0;
      first_pos_r        <= '0;
      out_valid_r        <= 1'b0;
      out_found_r        <= 1'b0;
      out_pos_r          <= '0;
    end else begin
      if (cfg_wr && cfg_index == CFG_NEEDLE_LENGTH) begin
        needle_length_r <= cfg_data[LEN_W-1:0];
      end
      if (cfg_wr && cfg_index == CFG_CASE_INSENSITIVE) begin
        case_insensitive_r <= cfg_data[0];
      end
      if (accept && in_last_char) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_last_char) begin
          char_count_r <= '0;
          found_flag_r <= 1'b0;
          first_pos_r  <= '0;
          out_found_r  <= found_nxt;
          out_pos_r    <= pos_nxt;
        end else begin
          if (char_count_r != COUNT_MAX) begin
            char_count_r <= char_count_r + POS_W'(1);
          end
          found_flag_r <= found_nxt;
          first_pos_r  <= pos_nxt;
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;

endmodule

>>> rtl/ssm_cell.sv
// One cell of the matcher chain: a needle character and its partial-match bit.
module ssm_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssm_pkg::cell_ctl_t                ctl,
  input  logic                              enable,
  input  logic                              cfg_we,
  input  logic [ssm_pkg::CHAR_W-1:0]        cfg_char,
  input  logic                              prev_bit,
  output logic                              pm_bit,
  output logic                              hit_nxt
);
  import ssm_pkg::*;

  logic [CHAR_W-1:0] needle_r;
  logic              pm_bit_r;
  logic              pm_bit_nxt;

  always_comb begin
    pm_bit_nxt = prev_bit & enable &
                 (fold_char(needle_r, ctl.case_insensitive) == ctl.hay_char);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r <= '0;
      pm_bit_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        needle_r <= cfg_char;
      end
      if (ctl.accept) begin
        pm_bit_r <= ctl.last ? 1'b0 : pm_bit_nxt;
      end
    end
  end

  assign pm_bit  = pm_bit_r;
  assign hit_nxt = pm_bit_nxt;

endmodule

>>> rtl/ssm_checker.sv
// Port-level checker of the matcher top level, with its bind statement.
module ssm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_char,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [14:0] out_match_position
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found)
      && $stable(out_match_position))
    else $error("Stalled result changed or was dropped.");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_position == 15'd0)
    else $error("Result without a match carries a nonzero position.");

  a_rose_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_char))
    else $error("Result appeared without a last-character transaction.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while no result was waiting.");

endmodule

bind streaming_substring_matcher_core ssm_checker u_ssm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_last_char       (in_last_char),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_found          (out_found),
  .out_match_position (out_match_position)
);

>>> tb/testbench.sv
// Testbench of the streaming substring matcher: directed and random haystacks against a predictor.
module testbench;
  import ssm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [15:0]          in_haystack_char = '0;
  logic                 in_last_char = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found;
  logic [14:0]          out_match_position;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  // Shadow copy of the registers and the per-haystack search state.
  logic [LEN_W-1:0]      needle_len = '0;
  logic                  fold_case = 1'b0;
  logic [63:0]           needle_words [NUM_WORDS];
  logic [MAX_NEEDLE-1:0] prefix_hits = '0;
  logic [POS_W-1:0]      char_index = '0;
  logic                  hit_seen = 1'b0;
  logic [POS_W-1:0]      hit_start = '0;

  search_result_t expected_matches [$];
  int             mismatch_count = 0;
  int             chars_sent = 0;
  int             gap_pct = 20;
  int             stall_pct = 20;

  streaming_substring_matcher_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_haystack_char   (in_haystack_char),
    .in_last_char       (in_last_char),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_match_position (out_match_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      needle_words[w] = '0;
    end
  end

  function automatic int active_length();
    return (needle_len > MAX_NEEDLE) ? MAX_NEEDLE : int'(needle_len);
  endfunction

  function automatic logic [15:0] needle_char(input int j);
    return needle_words[j >> 2][16 * (j & 3) +: 16];
  endfunction

  function automatic logic [15:0] upper_if_folding(input logic [15:0] c);
    if (fold_case && c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_DELTA;
    end
    return c;
  endfunction

  function automatic logic [15:0] swap_case(input logic [15:0] c);
    if (c >= 16'h0061 && c <= 16'h007A) begin
      return c - 16'h0020;
    end
    if (c >= 16'h0041 && c <= 16'h005A) begin
      return c + 16'h0020;
    end
    return c;
  endfunction

  function automatic logic [15:0] vary_case(input logic [15:0] c);
    if ($urandom_range(0, fold_case ? 1 : 7) == 0) begin
      return swap_case(c);
    end
    return c;
  endfunction

  function automatic logic [15:0] pick_char();
    case ($urandom_range(0, 11))
      0: return 16'h0041;
      1: return 16'h0061;
      2: return 16'h005A;
      3: return 16'h007A;
      4: return 16'h0040;
      5: return 16'h005B;
      6: return 16'h0060;
      7: return 16'h007B;
      8: return 16'h0161;
      9: return 16'h0000;
      10: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int idle_level();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 40;
    endcase
  endfunction

  function automatic void advance_search(input logic [15:0] ch, input logic is_last);
    int                    eff;
    logic [MAX_NEEDLE-1:0] hits_mask;
    search_result_t        res;
    eff = active_length();
    hits_mask = '0;
    for (int j = 0; j < eff; j++) begin
      if (upper_if_folding(needle_char(j)) == upper_if_folding(ch)) begin
        hits_mask[j] = 1'b1;
      end
    end
    prefix_hits = {prefix_hits[MAX_NEEDLE-2:0], 1'b1} & hits_mask;
    if (eff != 0 && !hit_seen && prefix_hits[eff-1]) begin
      hit_seen = 1'b1;
      hit_start = char_index - POS_W'(eff - 1);
    end
    if (char_index != COUNT_MAX) begin
      char_index++;
    end
    if (is_last) begin
      res.found = hit_seen;
      res.position = hit_seen ? hit_start : '0;
      expected_matches.push_back(res);
      prefix_hits = '0;
      char_index = '0;
      hit_seen = 1'b0;
      hit_start = '0;
    end
  endfunction

  task automatic send_char(input logic [15:0] ch, input logic is_last);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_haystack_char <= ch;
    in_last_char <= is_last;
    do @(posedge clk); while (in_stall);
    advance_search(ch, is_last);
    chars_sent++;
  endtask

  task automatic send_string(input logic [511:0] text, input int n);
    for (int k = 0; k < n; k++) begin
      send_char(text[16 * k +: 16], k == n - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NEEDLE_LENGTH:    needle_len = value[LEN_W-1:0];
      CFG_CASE_INSENSITIVE: fold_case = value[0];
      CFG_NEEDLE_WORD_0, CFG_NEEDLE_WORD_1, CFG_NEEDLE_WORD_2, CFG_NEEDLE_WORD_3: begin
        needle_words[idx - CFG_NEEDLE_WORD_0] = value;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_needle(input logic [255:0] chars, input logic [63:0] len_word,
                             input logic [63:0] ci_word);
    wait_idle();
    write_reg(CFG_NEEDLE_LENGTH, len_word);
    write_reg(CFG_CASE_INSENSITIVE, ci_word);
    write_reg(CFG_NEEDLE_WORD_0, chars[63:0]);
    write_reg(CFG_NEEDLE_WORD_1, chars[127:64]);
    write_reg(CFG_NEEDLE_WORD_2, chars[191:128]);
    write_reg(CFG_NEEDLE_WORD_3, chars[255:192]);
  endtask

  task automatic test_zero_length();
    send_string(512'(16'h0000), 1);
  endtask

  task automatic test_overlap();
    load_needle(256'({16'h0042, 16'h0041, 16'h0041}), 64'd3, 64'd0);
    send_string(512'({16'h0042, 16'h0041, 16'h0041, 16'h0042, 16'h0041, 16'h0041,
                      16'h0041}), 7);
  endtask

  task automatic test_short_haystack();
    send_string(512'({16'h0041, 16'h0041}), 2);
  endtask

  task automatic test_case_fold();
    load_needle(256'({16'h005A, 16'h0061}), 64'd2, 64'd1);
    send_string(512'({16'h007A, 16'h0041}), 2);
    load_needle(256'({16'h007B, 16'h0061}), 64'd2, 64'd1);
    send_string(512'({16'h005B, 16'h0041}), 2);
  endtask

  task automatic test_single_char();
    load_needle(256'(16'hFFFF), 64'd1, 64'd0);
    send_string(512'(16'hFFFF), 1);
  endtask

  task automatic test_full_needle();
    logic [255:0] chars;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      chars[16 * j +: 16] = (j == 0) ? 16'h0000 : (j == 1) ? 16'hFFFF : {4'(j), 12'h0A5};
    end
    load_needle(chars, 64'd31, 64'd0);
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      send_char(chars[16 * j +: 16], j == MAX_NEEDLE - 1);
    end
  endtask

  task automatic test_random_haystacks(input int target, input bit quiet);
    int             start_count;
    int             len_field;
    int             eff;
    int             hay_len;
    int             at;
    logic [15:0]    c;
    logic [255:0]   chars;
    logic [15:0]    hay [$];
    start_count = chars_sent;
    while (chars_sent - start_count < target) begin
      for (int j = 0; j < MAX_NEEDLE; j++) begin
        chars[16 * j +: 16] = pick_char();
      end
      case ($urandom_range(0, 9))
        0: len_field = 0;
        1: len_field = $urandom_range(17, 31);
        2: len_field = 16;
        3: len_field = $urandom_range(9, 16);
        default: len_field = $urandom_range(1, 8);
      endcase
      load_needle(chars, {$urandom, 27'($urandom), 5'(len_field)},
                  {$urandom, 31'($urandom), 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
      end
      gap_pct = quiet ? 0 : idle_level();
      stall_pct = quiet ? 0 : idle_level();
      eff = active_length();
      repeat ($urandom_range(4, 12)) begin
        hay_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        hay.delete();
        repeat (hay_len) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              c = (eff != 0) ? vary_case(needle_char($urandom_range(0, eff - 1))) : pick_char();
            end
            6, 7, 8: c = pick_char();
            default: c = 16'($urandom);
          endcase
          hay.push_back(c);
        end
        if (eff != 0 && eff <= hay_len && $urandom_range(0, 1) != 0) begin
          at = $urandom_range(0, hay_len - eff);
          for (int j = 0; j < eff; j++) begin
            hay[at + j] = vary_case(needle_char(j));
          end
        end
        foreach (hay[k]) begin
          send_char(hay[k], k == hay.size() - 1);
        end
        if (!quiet && $urandom_range(0, 7) == 0) begin
          wait_idle();
        end
      end
    end
  endtask

  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (burst > 0) begin
        burst--;
        if (burst == 0) begin
          out_stall <= 1'b0;
        end
      end else if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("Unexpected transaction: found=%0b position=%0d", out_found,
                   out_match_position);
        end
        mismatch_count++;
      end else begin
        want = expected_matches.pop_front();
        if (out_found !== want.found || out_match_position !== want.position) begin
          if (mismatch_count < 10) begin
            $display("Mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                     want.found, want.position, out_found, out_match_position);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_length();
    test_overlap();
    test_short_haystack();
    test_case_fold();
    test_single_char();
    test_full_needle();
    test_random_haystacks(1750, 1'b0);
    test_random_haystacks(200, 1'b1);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
